// ----- rtl/core/dmmc_pkg.sv -----
package dmmc_pkg;

	// Controller modes, as reported on state_code
	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_CAL_OPEN  = 3'd1,
		MODE_CAL_CLOSE = 3'd2,
		MODE_OPEN      = 3'd3,
		MODE_CLOSE     = 3'd4,
		MODE_ERROR     = 3'd5
	} mode_t;

	// Command codes of a tick request
	localparam logic [1:0] CMD_NONE      = 2'd0;
	localparam logic [1:0] CMD_BUTTON    = 2'd1;
	localparam logic [1:0] CMD_CALIBRATE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_STEP_SIZE      = 2'd0;
	localparam logic [1:0] REG_STEP_INTERVAL  = 2'd1;
	localparam logic [1:0] REG_STALL_TIMEOUT  = 2'd2;
	localparam logic [1:0] REG_BLINK_INTERVAL = 2'd3;

	// Configuration reset values
	localparam logic [7:0]  STEP_SIZE_RST      = 8'd1;
	localparam logic [15:0] STEP_INTERVAL_RST  = 16'd2;
	localparam logic [15:0] STALL_TIMEOUT_RST  = 16'd3000;
	localparam logic [15:0] BLINK_INTERVAL_RST = 16'd500;

	typedef struct packed {
		logic [7:0]  step_size;
		logic [15:0] step_interval;
		logic [15:0] stall_timeout;
		logic [15:0] blink_interval;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         command;
		logic               left_hit;
		logic               right_hit;
		logic signed [15:0] enc;
	} tick_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [15:0] position;
		logic [14:0]        span;
		logic               open_next;
		logic               calibrated;
		logic [15:0]        pace;
		logic [15:0]        stall;
		logic signed [15:0] last_enc;
		logic               blink_phase;
		logic               led;
	} ctl_state_t;

	typedef struct packed {
		mode_t              state_code;
		logic               step_pulse;
		logic               step_toward_open;
		logic signed [15:0] door_position;
		logic [14:0]        travel_span;
		logic               is_calibrated;
		logic               command_rejected;
		logic               led_on;
	} result_t;

	function automatic logic is_moving(input mode_t m);
		return (m == MODE_CAL_OPEN) || (m == MODE_CAL_CLOSE) ||
			(m == MODE_OPEN) || (m == MODE_CLOSE);
	endfunction

endpackage

// ----- rtl/core/dmmc_tick.sv -----
module dmmc_tick (
	input  dmmc_pkg::cfg_t       cfg,
	input  dmmc_pkg::ctl_state_t cur,
	input  dmmc_pkg::tick_t      tk,
	output dmmc_pkg::ctl_state_t nxt,
	output dmmc_pkg::result_t    res
);
	import dmmc_pkg::*;

	typedef struct packed {
		logic pulse;
		logic toward;
		logic rejected;
	} evt_t;

	evt_t evt;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic ctl_state_t enter_mode(input ctl_state_t s, input mode_t m);
		ctl_state_t r;
		r = s;
		if (m == MODE_CAL_OPEN) begin
			r.calibrated = 1'b0;
			r.led        = 1'b0;
		end
		if (is_moving(m))
			r.stall = '0;
		r.pace = '0;
		r.mode = m;
		return r;
	endfunction

	function automatic logic signed [15:0] move_by(input logic signed [15:0] p,
		input logic [7:0] d, input logic up);
		logic signed [16:0] t;
		t = up ? ({p[15], p} + $signed({9'b0, d})) : ({p[15], p} - $signed({9'b0, d}));
		if (t[16] != t[15])
			return t[16] ? 16'sh8000 : 16'sh7FFF;
		return t[15:0];
	endfunction

	// Next state: encoder watch, command, then the handler of the mode
	always_comb begin
		ctl_state_t s;
		logic       due;
		logic [15:0] mag;
		s   = cur;
		due = 1'b0;
		mag = '0;
		evt = '0;

		// Restart the stall count on any encoder movement
		s.stall = sat_inc(s.stall);
		if (tk.enc != s.last_enc) begin
			s.last_enc = tk.enc;
			s.stall    = '0;
		end

		// Act on the command
		case (tk.command)
			CMD_CALIBRATE: s = enter_mode(s, MODE_CAL_OPEN);
			CMD_BUTTON: begin
				if (!s.calibrated)
					evt.rejected = 1'b1;
				else if (!is_moving(s.mode))
					s = enter_mode(s, s.open_next ? MODE_OPEN : MODE_CLOSE);
				else begin
					s.open_next = !s.open_next;
					s = enter_mode(s, MODE_IDLE);
				end
			end
			default: ;
		endcase

		// Run the mode handler
		case (s.mode)
			MODE_CAL_OPEN: begin
				if (tk.right_hit) begin
					s.position = '0;
					s = enter_mode(s, MODE_CAL_CLOSE);
				end else begin
					due    = s.pace >= cfg.step_interval;
					s.pace = due ? 16'd1 : sat_inc(s.pace);
					if (due) begin
						s.position = move_by(s.position, cfg.step_size, 1'b1);
						evt.pulse  = 1'b1;
						evt.toward = 1'b1;
					end
					if (s.stall > cfg.stall_timeout) begin
						s.calibrated = 1'b0;
						s = enter_mode(s, MODE_ERROR);
					end
				end
			end
			MODE_CAL_CLOSE: begin
				if (tk.left_hit) begin
					mag = s.position[15] ? (~s.position + 16'd1) : s.position;
					s.span       = mag[15] ? 15'h7FFF : mag[14:0];
					s.position   = '0;
					s.last_enc   = '0;
					s.open_next  = 1'b1;
					s.calibrated = 1'b1;
					s = enter_mode(s, MODE_IDLE);
				end else begin
					due    = s.pace >= cfg.step_interval;
					s.pace = due ? 16'd1 : sat_inc(s.pace);
					if (due) begin
						s.position = move_by(s.position, cfg.step_size, 1'b0);
						evt.pulse  = 1'b1;
					end
					if (s.stall > cfg.stall_timeout) begin
						s.calibrated = 1'b0;
						s = enter_mode(s, MODE_ERROR);
					end
				end
			end
			MODE_OPEN: begin
				if (s.position >= $signed({1'b0, s.span})) begin
					s.open_next = 1'b0;
					s = enter_mode(s, MODE_IDLE);
				end else begin
					due    = s.pace >= cfg.step_interval;
					s.pace = due ? 16'd1 : sat_inc(s.pace);
					if (due) begin
						s.position = move_by(s.position, cfg.step_size, 1'b1);
						evt.pulse  = 1'b1;
						evt.toward = 1'b1;
					end
					if (s.stall > cfg.stall_timeout) begin
						s.calibrated = 1'b0;
						s = enter_mode(s, MODE_ERROR);
					end
					// Overshoot past the learned span
					if (s.position > $signed({1'b0, s.span})) begin
						s.calibrated = 1'b0;
						s = enter_mode(s, MODE_ERROR);
					end
				end
			end
			MODE_CLOSE: begin
				if (s.position <= 16'sd0) begin
					s.open_next = 1'b1;
					s = enter_mode(s, MODE_IDLE);
				end else begin
					due    = s.pace >= cfg.step_interval;
					s.pace = due ? 16'd1 : sat_inc(s.pace);
					if (due) begin
						s.position = move_by(s.position, cfg.step_size, 1'b0);
						evt.pulse  = 1'b1;
					end
					if (s.stall > cfg.stall_timeout) begin
						s.calibrated = 1'b0;
						s = enter_mode(s, MODE_ERROR);
					end
					// Overshoot below the closed end
					if (s.position < 16'sd0) begin
						s.calibrated = 1'b0;
						s = enter_mode(s, MODE_ERROR);
					end
				end
			end
			MODE_ERROR: begin
				due    = s.pace >= cfg.blink_interval;
				s.pace = due ? 16'd1 : sat_inc(s.pace);
				if (due) begin
					s.led         = !s.blink_phase;
					s.blink_phase = !s.blink_phase;
				end
			end
			default: ;
		endcase

		nxt = s;
	end

	// Result fields from the new state and this tick's events
	always_comb begin
		res.state_code       = nxt.mode;
		res.step_pulse       = evt.pulse;
		res.step_toward_open = evt.toward;
		res.door_position    = nxt.position;
		res.travel_span      = nxt.span;
		res.is_calibrated    = nxt.calibrated;
		res.command_rejected = evt.rejected;
		res.led_on           = nxt.led;
	end

endmodule

// ----- rtl/core/door_motor_motion_controller_unit.sv -----
// Door motor motion controller. Each request is one millisecond tick carrying an optional
// command, both limit-switch levels and the encoder count; each tick yields exactly one
// result with the mode, the motor step pulse and direction, the tracked position, the
// learned span, the calibration flag, a rejected-button flag and the fault LED level.
// A tick is registered on entry, evaluated combinationally against the controller state and
// its result is held in an output register, so one tick is accepted every clock cycle while
// the output is not stalled, and a result passes the input register and then the output
// register; the rate is set by the state update loop. Configuration is written through
// cfg_write/cfg_index/cfg_data and should change only while no tick is in flight.
module door_motor_motion_controller_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic               left_limit_hit,
	input  logic               right_limit_hit,
	input  logic signed [15:0] encoder_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         state_code,
	output logic               step_pulse,
	output logic               step_toward_open,
	output logic signed [15:0] door_position,
	output logic [14:0]        travel_span,
	output logic               is_calibrated,
	output logic               command_rejected,
	output logic               led_on
);
	import dmmc_pkg::*;

	cfg_t       cfg_q;
	ctl_state_t st_q;
	ctl_state_t st_nxt;
	tick_t      tick_s1;
	logic       valid_s1;
	result_t    res_nxt;
	result_t    res_s2;
	logic       valid_s2;
	logic       adv;

	// Advance the input stage when the output register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size      <= STEP_SIZE_RST;
			cfg_q.step_interval  <= STEP_INTERVAL_RST;
			cfg_q.stall_timeout  <= STALL_TIMEOUT_RST;
			cfg_q.blink_interval <= BLINK_INTERVAL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STEP_SIZE:      cfg_q.step_size      <= cfg_data[7:0];
				REG_STEP_INTERVAL:  cfg_q.step_interval  <= cfg_data;
				REG_STALL_TIMEOUT:  cfg_q.stall_timeout  <= cfg_data;
				REG_BLINK_INTERVAL: cfg_q.blink_interval <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the incoming request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.command   <= command;
			tick_s1.left_hit  <= left_limit_hit;
			tick_s1.right_hit <= right_limit_hit;
			tick_s1.enc       <= encoder_position;
		end
	end

	dmmc_tick u_tick (
		.cfg (cfg_q),
		.cur (st_q),
		.tk  (tick_s1),
		.nxt (st_nxt),
		.res (res_nxt)
	);

	// Commit controller state as each tick passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '{mode: MODE_IDLE, default: '0};
		else if (adv)
			st_q <= st_nxt;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	assign out_valid        = valid_s2;
	assign state_code       = res_s2.state_code;
	assign step_pulse       = res_s2.step_pulse;
	assign step_toward_open = res_s2.step_toward_open;
	assign door_position    = res_s2.door_position;
	assign travel_span      = res_s2.travel_span;
	assign is_calibrated    = res_s2.is_calibrated;
	assign command_rejected = res_s2.command_rejected;
	assign led_on           = res_s2.led_on;

	// Error always drops calibration
	a_err_uncal: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_ERROR) |-> !st_q.calibrated)
		else $error("error mode with calibration still set");

	// A direction toward open only comes with a step
	a_dir_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_toward_open) |-> step_pulse)
		else $error("step direction without step pulse");

	// State only moves when a tick passes the input stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st_q))
		else $error("controller state changed without a tick");

	// An accepted request always lands in the input stage
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted request lost");

endmodule
